// ----- rtl/thw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thw_pkg - shared types and constants of the history table
// entry layout, per-cell probe and flag groups, result and opcode codes
// ----------------------------------------------------------------------------
package thw_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int META_BYTES      = 256;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_RID  = 3'd1;
  localparam logic [2:0] OP_RKEY = 3'd2;
  localparam logic [2:0] OP_CLR  = 3'd3;
  localparam logic [2:0] OP_LIM  = 3'd4;

  // result kinds
  localparam logic [2:0] K_ADDED    = 3'd0;
  localparam logic [2:0] K_MOVED    = 3'd1;
  localparam logic [2:0] K_REMOVED  = 3'd2;
  localparam logic [2:0] K_CLEARED  = 3'd3;
  localparam logic [2:0] K_ECHO     = 3'd4;
  localparam logic [2:0] K_REJECTED = 3'd5;
  localparam logic [2:0] K_NOTFOUND = 3'd6;

  // register indexes
  localparam logic [1:0] REG_MEM_LIMIT = 2'd0;
  localparam logic [1:0] REG_MAX_AGE   = 2'd1;
  localparam logic [1:0] REG_MAX_ITEMS = 2'd2;

  // cell commands
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_RIGHT = 2'd1;
  localparam logic [1:0] CELL_LEFT  = 2'd2;
  localparam logic [1:0] CELL_LOAD  = 2'd3;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] event_time;
    logic [31:0] store_time;
    logic [31:0] size;
    logic [31:0] ident;
  } entry_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] event_time;
    logic [31:0] now_time;
    logic [31:0] max_age;
    logic [31:0] target_id;
  } probe_t;

  typedef struct packed {
    logic key_eq;
    logic time_ge;
    logic aged;
    logic id_eq;
  } cell_flags_t;

endpackage

// ----- rtl/thw_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thw_cell - one table slot
// holds one entry, shifts it toward either neighbor and compares it to the item
// ----------------------------------------------------------------------------
module thw_cell import thw_pkg::*; (
  input  logic        clk,
  input  logic [1:0]  cmd,
  input  entry_t      left_i,
  input  entry_t      right_i,
  input  entry_t      load_i,
  input  probe_t      probe,
  output entry_t      ent_o,
  output cell_flags_t flags_o
);

  entry_t ent_r;
  entry_t ent_nxt;

  // next contents
  always_comb begin
    case (cmd)
      CELL_RIGHT: ent_nxt = right_i;
      CELL_LEFT:  ent_nxt = left_i;
      CELL_LOAD:  ent_nxt = load_i;
      default:    ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // local compares
  always_comb begin
    flags_o.key_eq  = (ent_r.key_high == probe.key_high) && (ent_r.key_low == probe.key_low);
    flags_o.time_ge = (ent_r.event_time >= probe.event_time);
    flags_o.aged    = ({1'b0, ent_r.store_time} + {1'b0, probe.max_age}) <
                      {1'b0, probe.now_time};
    flags_o.id_eq   = (ent_r.ident == probe.target_id);
  end

  assign ent_o = ent_r;

endmodule

// ----- rtl/thw_first.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thw_first - first set flag along the chain
// gives the one-hot first flag and the mask from it to the end of the row
// ----------------------------------------------------------------------------
module thw_first #(
  parameter int N = 32
) (
  input  logic [N-1:0] sel,
  output logic [N-1:0] first,
  output logic [N-1:0] pre
);

  // log-step prefix or
  always_comb begin
    pre = sel;
    for (int s = 1; s < N; s = s * 2) begin
      pre = pre | (pre << s);
    end
    first = pre & ~(pre << 1);
  end

endmodule

// ----- rtl/timestamp_ordered_history_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_history_table - event-time sorted entry table
// row of shifting cells under a small sequencer, apb register port
// ----------------------------------------------------------------------------
// One item at a time: busy stays high from acceptance until its final result
// has been placed on the out_ ports. Entries live in a row of TABLE_DEPTH
// cells that shift by one place for each removal or insertion. A reject,
// echo, remove, clear or unused opcode goes from the operation step straight
// to the done step; a new add passes through the full, insert, age, count and
// byte-budget steps, a moved add skips the full step and an apply-limits item
// starts at the age step, with one removal step per evicted entry. When a
// byte budget is set the byte total is summed one entry per cycle. Each result
// is held back until the next one or the end of the item so that the final
// one can carry out_last; out_valid lasts one cycle and is not stalled.
// ----------------------------------------------------------------------------
module timestamp_ordered_history_table import thw_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_low,
  input  logic [63:0] in_event_time,
  input  logic [31:0] in_now_time,
  input  logic [31:0] in_payload_size,
  input  logic        in_has_format,
  input  logic [31:0] in_target_id,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [31:0] out_item_id,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TOT_W = 33 + CNT_W;
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int LIM_W = (TOT_W > 48) ? TOT_W : 48;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OP   = 4'd1;
  localparam logic [3:0] S_FULL = 4'd2;
  localparam logic [3:0] S_INS  = 4'd3;
  localparam logic [3:0] S_AGE  = 4'd4;
  localparam logic [3:0] S_CNT  = 4'd5;
  localparam logic [3:0] S_BSUM = 4'd6;
  localparam logic [3:0] S_BYTE = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // registers
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      next_id_r, next_id_nxt;
  logic [31:0]      ins_id_r, ins_id_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [47:0]      mem_limit_r;
  logic [31:0]      max_age_r;
  logic [5:0]       max_items_r;

  logic [2:0]  op_r;
  logic [63:0] kh_r, kl_r, t_r;
  logic [31:0] now_r, sz_r, tgt_r;
  logic        fmt_r;

  logic        pend_v_r;
  logic [2:0]  pend_kind_r;
  logic [31:0] pend_id_r;
  logic        out_valid_r, out_last_r;
  logic [2:0]  out_kind_r;
  logic [31:0] out_id_r;

  // sequencer outputs
  logic        push;
  logic [2:0]  push_kind;
  logic [31:0] push_id;
  logic        flush;
  logic        do_remove, do_insert;

  // cell row
  entry_t      ent   [TABLE_DEPTH];
  cell_flags_t flags [TABLE_DEPTH];
  logic [1:0]  cmd   [TABLE_DEPTH];
  entry_t      load_ent;
  probe_t      probe;

  logic [TABLE_DEPTH-1:0] valid_v, sel_v, first_v, pre_v;
  logic        any_hit, hit_ge;
  logic [31:0] hit_id;
  logic [31:0] idx_size;
  logic        zero_key;
  logic [TOT_W-1:0] front_bytes;

  logic accept;
  logic cfg_wr;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = (state_r != S_IDLE);
  assign pready = 1'b1;

  assign zero_key = (kh_r == 64'd0) && (kl_r == 64'd0);

  always_comb begin
    probe.key_high   = kh_r;
    probe.key_low    = kl_r;
    probe.event_time = t_r;
    probe.now_time   = now_r;
    probe.max_age    = max_age_r;
    probe.target_id  = tgt_r;
    load_ent.key_high   = kh_r;
    load_ent.key_low    = kl_r;
    load_ent.event_time = t_r;
    load_ent.store_time = now_r;
    load_ent.size       = sz_r;
    load_ent.ident      = ins_id_r;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_t left_ent, right_ent;
      if (g == 0) begin : g_l0
        assign left_ent = load_ent;
      end else begin : g_ln
        assign left_ent = ent[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_rl
        assign right_ent = ent[g];
      end else begin : g_rn
        assign right_ent = ent[g+1];
      end
      thw_cell u_cell (
        .clk     (clk),
        .cmd     (cmd[g]),
        .left_i  (left_ent),
        .right_i (right_ent),
        .load_i  (load_ent),
        .probe   (probe),
        .ent_o   (ent[g]),
        .flags_o (flags[g])
      );
    end
  endgenerate

  // occupied cells and search vector for the current step
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      valid_v[i] = (CNT_W'(i) < count_r);
    end
    sel_v = '0;
    case (state_r)
      S_OP: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          sel_v[i] = valid_v[i] && ((op_r == OP_RID) ? flags[i].id_eq : flags[i].key_eq);
        end
      end
      S_FULL, S_CNT, S_BYTE: sel_v[0] = 1'b1;
      S_INS: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          sel_v[i] = !valid_v[i] || flags[i].time_ge;
        end
      end
      S_AGE: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          sel_v[i] = valid_v[i] && flags[i].aged;
        end
      end
      default: sel_v = '0;
    endcase
  end

  thw_first #(.N(TABLE_DEPTH)) u_first (
    .sel   (sel_v),
    .first (first_v),
    .pre   (pre_v)
  );

  // fields of the first hit and of the summing index
  always_comb begin
    any_hit  = |sel_v;
    hit_ge   = 1'b0;
    hit_id   = '0;
    idx_size = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_ge = hit_ge | (first_v[i] & flags[i].time_ge);
      hit_id = hit_id | ({32{first_v[i]}} & ent[i].ident);
      idx_size = idx_size | ({32{CNT_W'(i) == idx_r}} & ent[i].size);
    end
    front_bytes = TOT_W'(META_BYTES) + TOT_W'(ent[0].size);
  end

  // cell commands
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (do_remove) begin
        cmd[i] = pre_v[i] ? CELL_RIGHT : CELL_HOLD;
      end else if (do_insert) begin
        cmd[i] = first_v[i] ? CELL_LOAD : (pre_v[i] ? CELL_LEFT : CELL_HOLD);
      end else begin
        cmd[i] = CELL_HOLD;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    ins_id_nxt  = ins_id_r;
    idx_nxt     = idx_r;
    total_nxt   = total_r;
    push        = 1'b0;
    push_kind   = K_REMOVED;
    push_id     = hit_id;
    flush       = 1'b0;
    do_remove   = 1'b0;
    do_insert   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_OP;
      end
      S_OP: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_ADD: begin
            if (!fmt_r) begin
              push = 1'b1; push_kind = K_REJECTED; push_id = '0;
            end else if (!zero_key && any_hit) begin
              push = 1'b1;
              if (hit_ge) begin
                push_kind = K_ECHO;
              end else begin
                push_kind  = K_MOVED;
                do_remove  = 1'b1;
                count_nxt  = count_r - 1'b1;
                ins_id_nxt = hit_id;
                state_nxt  = S_INS;
              end
            end else begin
              push = 1'b1; push_kind = K_ADDED; push_id = next_id_r;
              ins_id_nxt  = next_id_r;
              next_id_nxt = next_id_r + 32'd1;
              state_nxt   = S_FULL;
            end
          end
          OP_RID, OP_RKEY: begin
            push = 1'b1;
            if (any_hit && !(op_r == OP_RKEY && zero_key)) begin
              do_remove = 1'b1;
              count_nxt = count_r - 1'b1;
            end else begin
              push_kind = K_NOTFOUND; push_id = '0;
            end
          end
          OP_CLR: begin
            if (count_r != '0) begin
              count_nxt = '0;
              push = 1'b1; push_kind = K_CLEARED; push_id = '0;
            end
          end
          OP_LIM:  state_nxt = S_AGE;
          default: state_nxt = S_DONE;
        endcase
      end
      S_FULL: begin
        if (count_r == DEPTH_C) begin
          push = 1'b1; do_remove = 1'b1; count_nxt = count_r - 1'b1;
        end
        state_nxt = S_INS;
      end
      S_INS: begin
        do_insert = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_AGE;
      end
      S_AGE: begin
        if (max_age_r != '0 && any_hit) begin
          push = 1'b1; do_remove = 1'b1; count_nxt = count_r - 1'b1;
        end else begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if (max_items_r != '0 && CMP_W'(count_r) > CMP_W'(max_items_r)) begin
          push = 1'b1; do_remove = 1'b1; count_nxt = count_r - 1'b1;
        end else begin
          idx_nxt   = '0;
          total_nxt = '0;
          state_nxt = S_BSUM;
        end
      end
      S_BSUM: begin
        if (mem_limit_r == '0) begin
          state_nxt = S_DONE;
        end else if (idx_r == count_r) begin
          state_nxt = S_BYTE;
        end else begin
          total_nxt = total_r + TOT_W'(META_BYTES) + TOT_W'(idx_size);
          idx_nxt   = idx_r + 1'b1;
        end
      end
      S_BYTE: begin
        if (count_r > CNT_W'(1) && LIM_W'(total_r) > LIM_W'(mem_limit_r)) begin
          push = 1'b1; do_remove = 1'b1; count_nxt = count_r - 1'b1;
          total_nxt = (front_bytes >= total_r) ? '0 : total_r - front_bytes;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        flush     = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_id_r   <= 32'd1;
      mem_limit_r <= '0;
      max_age_r   <= '0;
      max_items_r <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      if (cfg_wr) begin
        case (paddr[4:3])
          REG_MEM_LIMIT: mem_limit_r <= pwdata[47:0];
          REG_MAX_AGE:   max_age_r   <= pwdata[31:0];
          REG_MAX_ITEMS: max_items_r <= pwdata[5:0];
          default: ;
        endcase
      end
      // one result held back so the final one can be marked
      out_valid_r <= 1'b0;
      if (push) begin
        out_valid_r <= pend_v_r;
        pend_v_r    <= 1'b1;
      end else if (flush) begin
        out_valid_r <= pend_v_r;
        pend_v_r    <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ins_id_r <= ins_id_nxt;
    idx_r    <= idx_nxt;
    total_r  <= total_nxt;
    if (accept) begin
      op_r  <= in_opcode;
      kh_r  <= in_key_high;
      kl_r  <= in_key_low;
      t_r   <= in_event_time;
      now_r <= in_now_time;
      sz_r  <= in_payload_size;
      fmt_r <= in_has_format;
      tgt_r <= in_target_id;
    end
    if (push) begin
      pend_kind_r <= push_kind;
      pend_id_r   <= push_id;
    end
    if (push || flush) begin
      out_kind_r <= pend_kind_r;
      out_id_r   <= pend_id_r;
      out_last_r <= flush;
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:3])
      REG_MEM_LIMIT: prdata = {16'd0, mem_limit_r};
      REG_MAX_AGE:   prdata = {32'd0, max_age_r};
      REG_MAX_ITEMS: prdata = {58'd0, max_items_r};
      default:       prdata = '0;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_item_id = out_id_r;
  assign out_last    = out_last_r;

endmodule

// ----- rtl/thw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thw_checker - port-level checks of the history table
// result marking against busy, zero ids and reset behavior
// ----------------------------------------------------------------------------
module thw_checker import thw_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_kind,
  input logic [31:0] out_item_id,
  input logic        out_last
);

  // final item of a command shows once the block is free again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result while busy");

  // earlier results appear only while the command is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");

  // an accepted item makes the block busy
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // kinds without an entry carry id zero
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_CLEARED || out_kind == K_REJECTED ||
                  out_kind == K_NOTFOUND) |-> out_item_id == 32'd0)
    else $error("nonzero id on id-less result");

  // reset leaves the block idle and quiet
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

endmodule

bind timestamp_ordered_history_table thw_checker u_thw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_kind    (out_kind),
  .out_item_id (out_item_id),
  .out_last    (out_last)
);
